// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Operation codes, states and fixed field widths of the deque unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned CNT_OUT_W  = 5;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned S_TUSER_W  = OP_W;
  localparam int unsigned M_TDATA_W  = 3 * FIELD_W + 3 + CNT_OUT_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_STATUS     = 3'd4
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } deq_state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } deq_mem_cmd_t;

endpackage

// ===== hw/rtl/deq_store.sv =====
// ----------------------------------------------------------------------------
// deq_store
// Ring store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_store
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  deq_mem_cmd_t          cmd_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [DATA_WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]         rd_addr_i,
  output logic [DATA_WIDTH-1:0] rd_data_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Pointer, count and end-word control with the result handshake.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = $clog2(DEPTH),
  parameter int unsigned CW         = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  deq_op_e               op_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] popped_o,
  output logic [DATA_WIDTH-1:0] front_o,
  output logic [DATA_WIDTH-1:0] back_o,
  output logic                  empty_o,
  output logic                  full_o,
  output logic [CW-1:0]         count_o,
  output logic                  refused_o,
  output deq_mem_cmd_t          mem_cmd_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [DATA_WIDTH-1:0] wr_data_o,
  output logic [AW-1:0]         rd_addr_o,
  input  logic [DATA_WIDTH-1:0] rd_data_i
);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  deq_state_e            state_q, state_d;
  logic [AW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic                  refused_q, refused_d;
  logic                  fill_front_q, fill_front_d;
  logic [DATA_WIDTH-1:0] front_q, front_d, back_q, back_d, popped_q, popped_d;
  logic                  in_fire, is_empty, is_full;

  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CW'(DEPTH));
  // Take a new item only once the previous result is gone or leaving.
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    front_d      = front_q;
    back_d       = back_q;
    popped_d     = popped_q;
    refused_d    = refused_q;
    fill_front_d = fill_front_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_cmd_o    = '0;
    wr_addr_o    = tail_q;
    wr_data_o    = word_i;
    rd_addr_o    = head_q;

    unique case (state_q)
      ST_FILL: begin
        // Refresh the end word exposed by the pop.
        if (fill_front_q) begin
          front_d = rd_data_i;
        end else begin
          back_d = rd_data_i;
        end
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          popped_d    = '0;
          refused_d   = 1'b0;
          out_valid_d = 1'b1;
          case (op_i) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (is_full) begin
                refused_d = 1'b1;
              end else begin
                count_d          = count_q + 1'b1;
                mem_cmd_o.wr_en  = 1'b1;
                if (op_i == OP_PUSH_FRONT) begin
                  head_d    = idx_dec(head_q);
                  wr_addr_o = idx_dec(head_q);
                  front_d   = word_i;
                  if (is_empty) begin
                    back_d = word_i;
                  end
                end else begin
                  wr_addr_o = tail_q;
                  tail_d    = idx_inc(tail_q);
                  back_d    = word_i;
                  if (is_empty) begin
                    front_d = word_i;
                  end
                end
              end
            end
            OP_POP_FRONT: begin
              if (!is_empty) begin
                popped_d = front_q;
                head_d   = idx_inc(head_q);
                count_d  = count_q - 1'b1;
                if (count_q == CW'(2)) begin
                  front_d = back_q;
                end else if (count_q > CW'(2)) begin
                  // New front sits in the slot after the popped one.
                  mem_cmd_o.rd_en = 1'b1;
                  rd_addr_o       = idx_inc(head_q);
                  fill_front_d    = 1'b1;
                  out_valid_d     = 1'b0;
                  state_d         = ST_FILL;
                end
              end
            end
            OP_POP_BACK: begin
              if (!is_empty) begin
                popped_d = back_q;
                tail_d   = idx_dec(tail_q);
                count_d  = count_q - 1'b1;
                if (count_q == CW'(2)) begin
                  back_d = front_q;
                end else if (count_q > CW'(2)) begin
                  mem_cmd_o.rd_en = 1'b1;
                  rd_addr_o       = idx_dec(idx_dec(tail_q));
                  fill_front_d    = 1'b0;
                  out_valid_d     = 1'b0;
                  state_d         = ST_FILL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    back_q       <= back_d;
    popped_q     <= popped_d;
    refused_q    <= refused_d;
    fill_front_q <= fill_front_d;
  end

  assign out_valid_o = out_valid_q;
  assign popped_o    = popped_q;
  assign front_o     = is_empty ? '0 : front_q;
  assign back_o      = is_empty ? '0 : back_q;
  assign empty_o     = is_empty;
  assign full_o      = is_full;
  assign count_o     = count_q;
  assign refused_o   = refused_q;

endmodule

// ===== hw/rtl/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of words in a ring store, streaming operation in and status out.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation (push front, push back, pop front,
// pop back or status; unused codes act as status) and returns exactly one
// result transfer holding the popped word (0 when nothing was popped), the
// front and back words (0 when empty), the empty and full flags, the entry
// count and a refused flag for a push into a full deque, which is dropped.
// Push, status and any pop that leaves at most one entry are answered from
// IDLE; a pop that leaves two or more entries passes through FILL, since the
// newly exposed end word is read from the ring store, whose read data is
// registered. The front and back words are held in registers, so only those
// pops touch the read port. One item is in flight at a time: the next can be
// accepted in the cycle its predecessor's result is taken. The store needs no
// clearing pass after reset; an entry is read only after it was written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // push_value [31:0]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // op [2:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // popped_value [31:0], front_value [63:32], back_value [95:64],
  // is_empty [96], is_full [97], entry_count [102:98], refused [103]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  deq_mem_cmd_t          mem_cmd;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data, word;
  logic [DATA_WIDTH-1:0] popped, front, back;
  logic                  empty, full, refused;
  logic [CW-1:0]         count;

  // Fit the incoming word to the store width (zero fill or drop high bits).
  assign word = DATA_WIDTH'(s_axis_tdata[FIELD_W-1:0]);

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (deq_op_e'(s_axis_tuser)),
    .word_i      (word),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .popped_o    (popped),
    .front_o     (front),
    .back_o      (back),
    .empty_o     (empty),
    .full_o      (full),
    .count_o     (count),
    .refused_o   (refused),
    .mem_cmd_o   (mem_cmd),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  // Reads and writes never hit the same entry in one cycle: a pop only reads.
  deq_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_store (
    .clk_i     (clk_i),
    .cmd_i     (mem_cmd),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Pack the result; words carry their low bits, count is taken modulo 32.
  assign m_axis_tdata = {refused,
                         CNT_OUT_W'(count),
                         full,
                         empty,
                         FIELD_W'(back),
                         FIELD_W'(front),
                         FIELD_W'(popped)};

endmodule

// ===== hw/rtl/deq_chk.sv =====
// ----------------------------------------------------------------------------
// deq_chk
// Port-level checks of the deque unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deq_chk
  import deq_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic                 r_empty, r_full, r_refused;
  logic [CNT_OUT_W-1:0] r_count;
  logic [FIELD_W-1:0]   r_front, r_back;

  assign r_front   = m_axis_tdata[2*FIELD_W-1:FIELD_W];
  assign r_back    = m_axis_tdata[3*FIELD_W-1:2*FIELD_W];
  assign r_empty   = m_axis_tdata[3*FIELD_W];
  assign r_full    = m_axis_tdata[3*FIELD_W+1];
  assign r_count   = m_axis_tdata[3*FIELD_W+2+CNT_OUT_W-1:3*FIELD_W+2];
  assign r_refused = m_axis_tdata[M_TDATA_W-1];

  `ASSERT_RST(a_empty_count, clk_i, rst_ni,
    m_axis_tvalid |-> (r_empty == (r_count == '0)),
    "empty flag disagrees with count")
  `ASSERT_RST(a_empty_ends, clk_i, rst_ni,
    m_axis_tvalid && r_empty |-> (r_front == '0) && (r_back == '0) && !r_full,
    "empty deque shows end words")
  `ASSERT_RST(a_refused_full, clk_i, rst_ni,
    m_axis_tvalid && r_refused |-> r_full,
    "push refused while not full")
  `ASSERT_RST(a_no_overtake, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && m_axis_tvalid |-> m_axis_tready,
    "item taken while a result waits")
  `ASSERT_RST(a_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")

endmodule

bind double_ended_queue_unit deq_chk u_deq_chk (.*);

// ===== tb/tb_double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Self-checking bench for the streaming deque unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked operations comes first: status and pops on an
// empty deque, pushes of the extreme words, a wrap of both pointers below
// slot zero, the spare operation codes, a fill to the brim and a refused push.
// Rows whose outcome is plain are checked against typed-in results; the rest,
// and a long random run built from fill, drain and mixed bursts, are checked
// against a shadow deque kept in the bench. Both stream sides idle at random,
// the output side once holds off long enough to stall the input, and the
// input side waits until every result is back, once midway and at the end.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned PTR_W          = $clog2(DEPTH);
  localparam int          RANDOM_ITEMS   = 1620;
  localparam int          HOLD_CYCLES    = 200;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 10;

  // Spare operation codes; the unit treats them as a status read.
  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

  // Result layout, highest field first so that it overlays m_axis_tdata.
  typedef struct packed {
    logic                 refused;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_full;
    logic                 is_empty;
    logic [FIELD_W-1:0]   back_value;
    logic [FIELD_W-1:0]   front_value;
    logic [FIELD_W-1:0]   popped_value;
  } deq_status_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] word;
    int                 reps;
    bit                 pinned;
    deq_status_t        status;
  } stim_row_t;

  typedef enum int {
    BIAS_FILL,
    BIAS_DRAIN,
    BIAS_MIXED
  } bias_e;

  bit                  clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Shadow deque: ring, front slot, slot one past the back, entries held.
  logic [FIELD_W-1:0] shadow_ring [DEPTH];
  logic [PTR_W-1:0]   shadow_head;
  logic [PTR_W-1:0]   shadow_tail;
  int                 shadow_held;

  deq_status_t awaited_status [$];
  stim_row_t   directed_rows [$];

  // Typed-in result for the item currently offered, if its row carries one.
  bit          pinned_now;
  deq_status_t pinned_status;

  int items_accepted;
  int results_seen;
  int mismatches;
  int quiet_cycles;
  int hold_requests;
  int holds_served;

  int push_ops;
  int pop_ops;
  int status_ops;
  int refused_pushes;
  int empty_pops;
  int full_results;

  double_ended_queue_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (FIELD_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow deque
  // --------------------------------------------------------------------------
  // Apply one operation to the shadow copy and return the status the unit
  // should report. Pointers are PTR_W bits wide, so they wrap modulo DEPTH.
  function automatic deq_status_t advance_deque(logic [OP_W-1:0] op,
                                                logic [FIELD_W-1:0] word);
    deq_status_t      res;
    logic [PTR_W-1:0] last_slot;
    res = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_held >= DEPTH) begin
          res.refused = 1'b1;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_head              = shadow_head - 1'b1;
          shadow_ring[shadow_head] = word;
          shadow_held++;
        end else begin
          shadow_ring[shadow_tail] = word;
          shadow_tail              = shadow_tail + 1'b1;
          shadow_held++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_held > 0) begin
          res.popped_value = shadow_ring[shadow_head];
          shadow_head      = shadow_head + 1'b1;
          shadow_held--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_held > 0) begin
          shadow_tail      = shadow_tail - 1'b1;
          res.popped_value = shadow_ring[shadow_tail];
          shadow_held--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_held > 0) begin
      last_slot       = shadow_tail - 1'b1;
      res.front_value = shadow_ring[shadow_head];
      res.back_value  = shadow_ring[last_slot];
    end
    res.is_empty    = (shadow_held == 0);
    res.is_full     = (shadow_held >= DEPTH);
    res.entry_count = shadow_held[CNT_OUT_W-1:0];
    return res;
  endfunction

  // Build a typed-in result; the flags follow from the count.
  function automatic deq_status_t status_of(logic [FIELD_W-1:0] popped,
                                            logic [FIELD_W-1:0] front,
                                            logic [FIELD_W-1:0] back,
                                            int count, bit refused);
    deq_status_t res;
    res.popped_value = popped;
    res.front_value  = front;
    res.back_value   = back;
    res.is_empty     = (count == 0);
    res.is_full      = (count == DEPTH);
    res.entry_count  = count[CNT_OUT_W-1:0];
    res.refused      = refused;
    return res;
  endfunction

  function automatic void add_row(logic [OP_W-1:0] op, logic [FIELD_W-1:0] word,
                                  int reps, bit pinned, deq_status_t status);
    stim_row_t row;
    row.op     = op;
    row.word   = word;
    row.reps   = reps;
    row.pinned = pinned;
    row.status = status;
    directed_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Random choices
  // --------------------------------------------------------------------------
  function automatic logic [OP_W-1:0] pick_op(bias_e bias);
    int roll;
    int push_below;
    int pop_below;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  begin push_below = 75; pop_below = 90; end
      BIAS_DRAIN: begin push_below = 15; pop_below = 90; end
      default:    begin push_below = 42; pop_below = 84; end
    endcase
    if (roll < push_below) begin
      return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else if (roll < pop_below) begin
      return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
    end
    // Status read, spare codes included.
    return OP_W'($urandom_range(OP_STATUS, OP_SPARE_HI));
  endfunction

  // Lean towards the extreme words now and then.
  function automatic logic [FIELD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one operation after an optional gap and hold it until the transfer.
  // Returns straight after the accepting rising edge.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] word,
                         input int gap, input bit pinned, input deq_status_t status);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pinned_now    = pinned;
    pinned_status = status;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic wait_all_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (results_seen == items_accepted);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("MISMATCH after %0d results: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                             input logic [FIELD_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    end
  endtask

  // Predict on each input transfer and compare on each output transfer in the same
  // process, so that the order of the two on the same clock edge never matters.
  always @(posedge clk_i) begin
    deq_status_t got;
    deq_status_t want;
    bit          any_transfer;
    any_transfer = 1'b0;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      any_transfer = 1'b1;
      case (s_axis_tuser)
        OP_PUSH_FRONT, OP_PUSH_BACK: push_ops++;
        OP_POP_FRONT, OP_POP_BACK: begin
          pop_ops++;
          if (shadow_held == 0) empty_pops++;
        end
        default: status_ops++;
      endcase
      want = advance_deque(s_axis_tuser, s_axis_tdata);
      if (pinned_now) want = pinned_status;
      if (want.refused) refused_pushes++;
      if (want.is_full) full_results++;
      awaited_status.push_back(want);
      items_accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      any_transfer = 1'b1;
      got = m_axis_tdata;
      results_seen++;
      if (awaited_status.size() == 0) begin
        report_mismatch($sformatf("result %h with none expected", m_axis_tdata));
      end else begin
        want = awaited_status.pop_front();
        check_field("popped_value", got.popped_value, want.popped_value);
        check_field("front_value",  got.front_value,  want.front_value);
        check_field("back_value",   got.back_value,   want.back_value);
        check_field("is_empty",     got.is_empty,     want.is_empty);
        check_field("is_full",      got.is_full,      want.is_full);
        check_field("entry_count",  got.entry_count,  want.entry_count);
        check_field("refused",      got.refused,      want.refused);
      end
    end
    quiet_cycles = any_transfer ? 0 : quiet_cycles + 1;
  end

  // End the run if nothing moves on either side for too long.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  // Pick a ready level and hold it for a span of cycles; serve a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    logic level;
    int   span;
    int   roll;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        level = 1'b0;
        span  = HOLD_CYCLES;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          level = 1'b1;
          span  = $urandom_range(50, 150);
        end else if (roll < 55) begin
          level = 1'b1;
          span  = $urandom_range(1, 12);
        end else if (roll < 90) begin
          level = 1'b0;
          span  = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          span  = $urandom_range(8, 40);
        end
      end
      m_axis_tready <= level;
      repeat (span - 1) @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int    random_sent;
    int    burst_len;
    bias_e bias;
    bit    calm;
    bit    hold_asked;
    bit    pause_done;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_STATUS;
    pinned_now    = 1'b0;
    pinned_status = '0;
    shadow_head   = '0;
    shadow_tail   = '0;
    shadow_held   = 0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    random_sent   = 0;
    hold_asked    = 1'b0;
    pause_done    = 1'b0;

    // Empty deque: status and pops on both ends return zeros.
    add_row(OP_STATUS,     32'h0,        1, 1'b1, status_of(0, 0, 0, 0, 0));
    add_row(OP_POP_FRONT,  32'hDEAD_BEEF, 1, 1'b1, status_of(0, 0, 0, 0, 0));
    add_row(OP_POP_BACK,   32'hFFFF_FFFF, 1, 1'b1, status_of(0, 0, 0, 0, 0));
    // Extreme words in at both ends and out again.
    add_row(OP_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1,
            status_of(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0));
    add_row(OP_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
            status_of(0, 32'h8000_0000, 32'h7FFF_FFFF, 2, 0));
    add_row(OP_POP_BACK,   32'h0,        1, 1'b1,
            status_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 0));
    add_row(OP_POP_FRONT,  32'h0,        1, 1'b1,
            status_of(32'h8000_0000, 0, 0, 0, 0));
    // Both pointers step back below slot zero.
    add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b0, '0);
    add_row(OP_POP_BACK,   32'h0,        1, 1'b0, '0);
    // Spare codes act as status reads.
    add_row(OP_SPARE_LO,   32'h1234_5678, 1, 1'b0, '0);
    add_row(OP_SPARE_MID,  32'h0,        1, 1'b0, '0);
    add_row(OP_SPARE_HI,   32'hFFFF_FFFF, 1, 1'b0, '0);
    // Fill with 1..DEPTH, then pushes at both ends are refused.
    add_row(OP_PUSH_BACK,  32'h1,        DEPTH, 1'b0, '0);
    add_row(OP_PUSH_FRONT, 32'h0BAD_F00D, 1, 1'b1, status_of(0, 1, DEPTH, DEPTH, 1));
    add_row(OP_PUSH_BACK,  32'h55AA_55AA, 1, 1'b0, '0);
    add_row(OP_STATUS,     32'h0,        1, 1'b0, '0);
    add_row(OP_POP_FRONT,  32'h0,        3, 1'b0, '0);
    add_row(OP_POP_BACK,   32'h0,        3, 1'b0, '0);

    // Hold reset, then release it away from the rising edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the table; repeated rows count the word up from its base.
    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        send_op(directed_rows[i].op, directed_rows[i].word + k, pick_gap(),
                directed_rows[i].pinned, directed_rows[i].status);
      end
    end

    // Random bursts that push the deque towards full, towards empty, or
    // leave it wandering; calm bursts keep the input side busy throughout.
    while (random_sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(4, 40);
      bias      = bias_e'($urandom_range(BIAS_FILL, BIAS_MIXED));
      calm      = ($urandom_range(0, 4) == 0);
      if (!hold_asked && random_sent >= RANDOM_ITEMS / 4) begin
        // Hold off the output side and keep offering items meanwhile.
        hold_asked = 1'b1;
        hold_requests++;
        bias      = BIAS_FILL;
        calm      = 1'b1;
        burst_len = 40;
      end
      if (!pause_done && random_sent >= RANDOM_ITEMS / 2) begin
        pause_done = 1'b1;
        wait_all_results();
      end
      repeat (burst_len) begin
        send_op(pick_op(bias), pick_word(), calm ? 0 : pick_gap(), 1'b0, '0);
        random_sent++;
      end
    end

    // Drain, then let the bench settle before checking that no result is awaited.
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_status.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_status.size()));
    end

    $display("Covered %0d operations: %0d pushes, %0d pops, %0d status reads",
             items_accepted, push_ops, pop_ops, status_ops);
    $display("Refused pushes: %0d, pops on empty: %0d, results with a full deque: %0d",
             refused_pushes, empty_pops, full_results);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
